### hw/rtl/smpq_pkg.sv
// package for the sorted min-priority queue: sizes, codes and the
// command/status structs shared by the controller, datapath and top level
`timescale 1ns / 1ps

package smpq_pkg;

  // queue depth and derived widths
  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // field widths
  localparam int ID_W   = 16;
  localparam int DIST_W = 32;
  localparam int STAT_W = 2;

  // stream payload widths (whole bytes)
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  // operation codes carried on in_tuser
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // result status codes carried on out_tuser
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // controller states
  typedef enum logic [0:0] {
    S_IDLE,
    S_EXEC
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;       // latch the incoming transfer
    logic insert;        // shift the new entry into its sorted slot
    logic extract;       // pop the head entry
    logic drop_full;     // report a dropped insert
    logic report_empty;  // report an extract on an empty queue
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op;
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

### hw/rtl/smpq_ctrl.sv
// controller for the sorted min-priority queue: two-state sequencer and
// the output valid flag; uses smpq_pkg
`timescale 1ns / 1ps

module smpq_ctrl
  import smpq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_xfer;

  // input side opens when idle and the result register is free or draining
  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        cmd.capture = in_xfer;
      end
      S_EXEC: begin
        if (stat.op == OP_INSERT) begin
          cmd.insert    = !stat.full;
          cmd.drop_full = stat.full;
        end else begin
          cmd.extract      = !stat.empty;
          cmd.report_empty = stat.empty;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // result valid: set when a result is loaded, cleared on its transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (state_r == S_EXEC) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hw/rtl/smpq_datapath.sv
// datapath for the sorted min-priority queue: a row of sorted cells that
// compare and shift in parallel, the fill count and the result register;
// uses smpq_pkg
`timescale 1ns / 1ps

module smpq_datapath
  import smpq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  input  logic [IN_TDATA_W-1:0]   in_tdata,
  input  logic                    in_tuser,
  output logic [OUT_TDATA_W-1:0]  out_tdata,
  output logic [STAT_W-1:0]       out_tuser
);

  logic [DIST_W-1:0] key_r [CAPACITY];
  logic [ID_W-1:0]   id_r  [CAPACITY];
  logic [DIST_W-1:0] key_nxt [CAPACITY];
  logic [ID_W-1:0]   id_nxt  [CAPACITY];
  logic [CAPACITY-1:0] stay;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              op_r;
  logic [ID_W-1:0]   nid_r;
  logic [DIST_W-1:0] dist_r;

  logic [STAT_W-1:0] res_status_r;
  logic [ID_W-1:0]   res_id_r;
  logic [DIST_W-1:0] res_dist_r;
  logic              res_empty_r;

  assign stat.op    = op_r;
  assign stat.full  = (count_r == CNT_W'(CAPACITY));
  assign stat.empty = (count_r == '0);

  // per-cell compare and shift; stay marks occupied cells with key <= new key
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    assign stay[g] = (CNT_W'(g) < count_r) && (key_r[g] <= dist_r);

    always_comb begin
      key_nxt[g] = key_r[g];
      id_nxt[g]  = id_r[g];
      if (cmd.insert && !stay[g]) begin
        if (g == 0) begin
          key_nxt[g] = dist_r;
          id_nxt[g]  = nid_r;
        end else if (stay[(g > 0) ? g - 1 : 0]) begin
          key_nxt[g] = dist_r;
          id_nxt[g]  = nid_r;
        end else begin
          key_nxt[g] = key_r[(g > 0) ? g - 1 : 0];
          id_nxt[g]  = id_r[(g > 0) ? g - 1 : 0];
        end
      end else if (cmd.extract && (g < CAPACITY - 1)) begin
        key_nxt[g] = key_r[(g < CAPACITY - 1) ? g + 1 : g];
        id_nxt[g]  = id_r[(g < CAPACITY - 1) ? g + 1 : g];
      end
    end

    always_ff @(posedge clk) begin
      key_r[g] <= key_nxt[g];
      id_r[g]  <= id_nxt[g];
    end
  end

  // fill count
  always_comb begin
    count_nxt = count_r;
    if (cmd.insert) count_nxt = count_r + CNT_W'(1);
    else if (cmd.extract) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // input latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_tuser;
      nid_r  <= in_tdata[ID_W-1:0];
      dist_r <= in_tdata[ID_W+DIST_W-1:ID_W];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      res_status_r <= STAT_OK;
      res_id_r     <= '0;
      res_dist_r   <= '0;
      res_empty_r  <= 1'b0;
    end else if (cmd.drop_full) begin
      res_status_r <= STAT_FULL;
      res_id_r     <= '0;
      res_dist_r   <= '0;
      res_empty_r  <= 1'b0;
    end else if (cmd.extract) begin
      res_status_r <= STAT_OK;
      res_id_r     <= id_r[0];
      res_dist_r   <= key_r[0];
      res_empty_r  <= (count_r == CNT_W'(1));
    end else if (cmd.report_empty) begin
      res_status_r <= STAT_EMPTY;
      res_id_r     <= '0;
      res_dist_r   <= '1;
      res_empty_r  <= 1'b1;
    end
  end

  assign out_tdata = {(OUT_TDATA_W - ID_W - DIST_W - 1)'(0), res_empty_r, res_dist_r, res_id_r};
  assign out_tuser = res_status_r;

endmodule

### hw/rtl/sorted_min_priority_queue.sv
// Sorted min-priority queue of up to CAPACITY (64) entries of 16-bit node id and
// 32-bit distance, held in ascending distance order in a row of cells. An insert
// (in_tuser 0) lands after every stored entry of lower or equal distance, so
// equal distances leave in arrival order; an extract (in_tuser 1) returns the
// head entry. Every input transfer gives exactly one result transfer. The accept
// cycle latches an item; in the cycle after it, every cell compares against the
// new key and shifts at once, and the result register is loaded. One item is in
// flight at a time: a new item is taken in the cycle the previous result
// transfers (or earlier if the result register is already empty). No clearing
// pass after reset.
// depends on smpq_pkg, smpq_ctrl, smpq_datapath
`timescale 1ns / 1ps

module sorted_min_priority_queue
  import smpq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // node_id[15:0], distance[47:16]
  input  logic                   in_tuser,   // operation[0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // out_node_id[15:0], out_distance[47:16],
                                             // empty_after[48], zero fill [55:49]
  output logic [STAT_W-1:0]      out_tuser   // status[1:0]
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  smpq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // cell row and result register
  smpq_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

`ifndef SYNTHESIS
  // one item in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("accepted a second item while one is in flight");

  // an empty-queue extract reports all-ones distance and an empty queue
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == STAT_EMPTY)) |->
      (out_tdata[48] && (out_tdata[47:16] == '1) && (out_tdata[15:0] == '0)))
    else $error("empty extract result malformed");

  // never both an insert and an extract command together
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.insert, cmd.extract, cmd.drop_full, cmd.report_empty}) <= 1)
    else $error("conflicting datapath commands");

  // a dropped insert only happens on a full queue, which is never empty
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drop_full |-> (stat.full && !stat.empty))
    else $error("insert dropped while queue not full");
`endif

endmodule

### bench/tb.sv
// self-checking bench for sorted_min_priority_queue: directed table then random
// insert/extract phases; results checked against typed rows or a sorted-queue model
// depends on smpq_pkg and the sorted_min_priority_queue rtl
`timescale 1ns / 1ps

module tb
  import smpq_pkg::*;
;

  // one result of the queue
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   node_id;
    logic [DIST_W-1:0] distance;
    logic              empty_after;
  } pq_result_t;

  // one row of the directed table; known marks rows whose result is typed in
  typedef struct packed {
    logic              op;
    logic [ID_W-1:0]   node_id;
    logic [DIST_W-1:0] distance;
    logic              known;
    pq_result_t        result;
  } stim_row_t;

  localparam int NUM_ROWS = 18;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = OP_INSERT;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]      out_tuser;

  // model of the queue contents, head at index 0
  logic [DIST_W-1:0] sorted_keys[$];
  logic [ID_W-1:0]   sorted_ids[$];

  pq_result_t pending_results[$];
  stim_row_t  stim_table[NUM_ROWS];

  bit steady_flow = 1'b0;
  int errors = 0;
  int results_seen = 0;
  int n_popped = 0;
  int n_empty = 0;
  int n_dropped = 0;

  sorted_min_priority_queue u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // sink stalls about 20 percent of the time unless the flow is steady
  always @(posedge clk) begin
    out_tready <= steady_flow || ($urandom_range(0, 99) >= 20);
  end

  // expected result of one item, updates the model contents
  function automatic pq_result_t sorted_queue_predict(logic op, logic [ID_W-1:0] id,
                                                      logic [DIST_W-1:0] dist_val);
    pq_result_t r;
    int pos;
    r = '0;
    r.status = STAT_OK;
    if (op == OP_INSERT) begin
      if (sorted_keys.size() >= CAPACITY) begin
        r.status = STAT_FULL;
      end else begin
        // land behind every entry of lower or equal distance
        pos = 0;
        while (pos < sorted_keys.size() && sorted_keys[pos] <= dist_val) pos++;
        sorted_keys.insert(pos, dist_val);
        sorted_ids.insert(pos, id);
      end
    end else begin
      if (sorted_keys.size() == 0) begin
        r.status = STAT_EMPTY;
        r.distance = '1;
      end else begin
        r.node_id = sorted_ids.pop_front();
        r.distance = sorted_keys.pop_front();
        n_popped++;
      end
    end
    r.empty_after = (sorted_keys.size() == 0);
    return r;
  endfunction

  // distance mix: small values for ties, extremes, full range
  function automatic logic [DIST_W-1:0] pick_distance();
    case ($urandom_range(0, 3))
      0: return DIST_W'($urandom_range(0, 7));
      1: return $urandom_range(0, 1) ? '1 - DIST_W'($urandom_range(0, 2))
                                     : DIST_W'($urandom_range(0, 2));
      default: return $urandom;
    endcase
  endfunction

  task automatic check_field(string name, logic [DIST_W-1:0] exp_val,
                             logic [DIST_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  // result transfers checked against the oldest expectation
  always @(posedge clk) begin
    pq_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, actual status %h tdata %h",
                 $time, out_tuser, out_tdata);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        check_field("status", DIST_W'(exp_res.status), DIST_W'(out_tuser));
        check_field("node_id", DIST_W'(exp_res.node_id), DIST_W'(out_tdata[15:0]));
        check_field("distance", exp_res.distance, out_tdata[47:16]);
        check_field("empty_after", DIST_W'(exp_res.empty_after), DIST_W'(out_tdata[48]));
        check_field("zero fill", '0, DIST_W'(out_tdata[55:49]));
        case (exp_res.status)
          STAT_EMPTY: n_empty++;
          STAT_FULL:  n_dropped++;
          default:    ;
        endcase
      end
    end
  end

  // one input transfer with an occasional gap in front of it
  task automatic send_item(logic op, logic [ID_W-1:0] id, logic [DIST_W-1:0] dist_val,
                           logic known, pq_result_t known_res);
    pq_result_t predicted;
    if (!steady_flow && $urandom_range(0, 99) < 20) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {dist_val, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = sorted_queue_predict(op, id, dist_val);
    pending_results.push_back(known ? known_res : predicted);
  endtask

  // hold the sender until every result is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // random phase: ins_pct percent inserts, the rest extracts with junk payload
  task automatic run_phase(int count, int ins_pct, bit steady);
    logic op;
    steady_flow = steady;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_EXTRACT;
      send_item(op, ID_W'($urandom), pick_distance(), 1'b0, '0);
    end
    drain_results();
    steady_flow = 1'b0;
  endtask

  initial begin
    // directed table: empty queue, extremes, ties in arrival order
    stim_table = '{
      '{OP_EXTRACT, 16'h0000, 32'h00000000, 1'b1, '{STAT_EMPTY, 16'h0, 32'hFFFFFFFF, 1'b1}},
      '{OP_INSERT,  16'hFFFF, 32'hFFFFFFFF, 1'b1, '{STAT_OK, 16'h0, 32'h0, 1'b0}},
      '{OP_INSERT,  16'h0000, 32'h00000000, 1'b1, '{STAT_OK, 16'h0, 32'h0, 1'b0}},
      '{OP_INSERT,  16'h1234, 32'h00000005, 1'b0, '0},
      '{OP_INSERT,  16'h5678, 32'h00000005, 1'b0, '0},
      '{OP_INSERT,  16'hAAAA, 32'h80000000, 1'b0, '0},
      '{OP_INSERT,  16'h5555, 32'h7FFFFFFF, 1'b0, '0},
      '{OP_INSERT,  16'h0001, 32'hFFFFFFFF, 1'b0, '0},
      '{OP_EXTRACT, 16'hFFFF, 32'hFFFFFFFF, 1'b1, '{STAT_OK, 16'h0, 32'h0, 1'b0}},
      '{OP_EXTRACT, 16'h0000, 32'h00000000, 1'b0, '0},
      '{OP_EXTRACT, 16'h0000, 32'h00000000, 1'b0, '0},
      '{OP_EXTRACT, 16'h0000, 32'h00000000, 1'b0, '0},
      '{OP_EXTRACT, 16'h0000, 32'h00000000, 1'b0, '0},
      '{OP_EXTRACT, 16'h0000, 32'h00000000, 1'b0, '0},
      '{OP_EXTRACT, 16'h0000, 32'h00000000, 1'b0, '0},
      '{OP_EXTRACT, 16'hFFFF, 32'hFFFFFFFF, 1'b1, '{STAT_EMPTY, 16'h0, 32'hFFFFFFFF, 1'b1}},
      '{OP_INSERT,  16'hBEEF, 32'h00000000, 1'b0, '0},
      '{OP_EXTRACT, 16'h0000, 32'h00000000, 1'b0, '0}
    };

    // synchronous reset held low, then released
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i])
      send_item(stim_table[i].op, stim_table[i].node_id, stim_table[i].distance,
                stim_table[i].known, stim_table[i].result);
    drain_results();

    // fill past capacity so inserts get dropped, then drain past empty
    run_phase(72, 100, 1'b0);
    run_phase(72, 0, 1'b0);
    // mixed traffic, once with no gaps on either side
    run_phase(100, 50, 1'b1);
    run_phase(160, 55, 1'b0);

    repeat (8) @(posedge clk);
    $display("checked %0d results: %0d pops, %0d empty extracts, %0d dropped inserts",
             results_seen, n_popped, n_empty, n_dropped);
    $display("queue held %0d entries at the end, %0d errors", sorted_keys.size(), errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("FAIL");
    $finish;
  end

endmodule
